// ===== rtl/ats_pkg.sv =====
// Package for the table-driven arcsine unit: ROM tables and shared constants.
// Depends on nothing.
package ats_pkg;

   typedef logic [63:0][33:0] asin_table_type;
   typedef logic [63:0][32:0] cos_table_type;

   // asin(k/64) in Q.32, rounded to nearest
   function automatic logic [33:0] asin_rom(input logic [5:0] k);
      logic [63:0] bits;
      logic [10:0] e;
      logic [52:0] m;
      int sh;
      logic [63:0] r;
      unique case (k)
         6'd0: bits = 64'h0000000000000000; 6'd1: bits = 64'h3f90002aabdde94c;
         6'd2: bits = 64'h3fa000aabde0b9c8; 6'd3: bits = 64'h3fa8024091fdb0a9;
         6'd4: bits = 64'h3fb002abde953619; 6'd5: bits = 64'h3fb405390240e6fd;
         6'd6: bits = 64'h3fb809092913e52e; 6'd7: bits = 64'h3fbc0e5e80f7172d;
         6'd8: bits = 64'h3fc00abe0c129e1e; 6'd9: bits = 64'h3fc20f530308cc20;
         6'd10: bits = 64'h3fc41510cb011423; 6'd11: bits = 64'h3fc61c1ab9d55d30;
         6'd12: bits = 64'h3fc82494ed0e78fc; 6'd13: bits = 64'h3fca2ea462b4998e;
         6'd14: bits = 64'h3fcc3a6f13aae84b; 6'd15: bits = 64'h3fce481c0fce7134;
         6'd16: bits = 64'h3fd02be9ce0b87cd; 6'd17: bits = 64'h3fd134dfa9805147;
         6'd18: bits = 64'h3fd23f0523c5dc2b; 6'd19: bits = 64'h3fd34a709597aab1;
         6'd20: bits = 64'h3fd457393b90e2aa; 6'd21: bits = 64'h3fd565774cb66f02;
         6'd22: bits = 64'h3fd675441329986e; 6'd23: bits = 64'h3fd786ba074fef93;
         6'd24: bits = 64'h3fd899f4edc962d3; 6'd25: bits = 64'h3fd9af11f89ba61c;
         6'd26: bits = 64'h3fdac62fec0b2a92; 6'd27: bits = 64'h3fdbdf6f47ae6904;
         6'd28: bits = 64'h3fdcfaf27460fe9f; 6'd29: bits = 64'h3fde18ddf7da106b;
         6'd30: bits = 64'h3fdf3958aecddef4; 6'd31: bits = 64'h3fe02e46075785a1;
         6'd32: bits = 64'h3fe0c152382d7366; 6'd33: bits = 64'h3fe155e8b2a00052;
         6'd34: bits = 64'h3fe1ec230c714a96; 6'd35: bits = 64'h3fe2841ce0862975;
         6'd36: bits = 64'h3fe31df40fbd31cd; 6'd37: bits = 64'h3fe3b9c90c43296d;
         6'd38: bits = 64'h3fe457bf318fe517; 6'd39: bits = 64'h3fe4f7fd2bc2fb34;
         6'd40: bits = 64'h3fe59aad71ced00f; 6'd41: bits = 64'h3fe63ffed6d198f6;
         6'd42: bits = 64'h3fe6e825383cc40b; 6'd43: bits = 64'h3fe7935a501afa78;
         6'd44: bits = 64'h3fe841deb5114bb4; 6'd45: bits = 64'h3fe8f3fb14e496b4;
         6'd46: bits = 64'h3fe9aa01babef75e; 6'd47: bits = 64'h3fea645078c6a78c;
         6'd48: bits = 64'h3feb235315c680dc; 6'd49: bits = 64'h3febe7866d3b6481;
         6'd50: bits = 64'h3fecb17c849c7288; 6'd51: bits = 64'h3fed81e1f875ea8d;
         6'd52: bits = 64'h3fee5985567b665d; 6'd53: bits = 64'h3fef39614cbef7d4;
         6'd54: bits = 64'h3ff0115591d29d12; 6'd55: bits = 64'h3ff08b73f9af1058;
         6'd56: bits = 64'h3ff10c066d3e6932; 6'd57: bits = 64'h3ff194590de7e7f6;
         6'd58: bits = 64'h3ff2263461820ad8; 6'd59: bits = 64'h3ff2c42a3a3c7a87;
         6'd60: bits = 64'h3ff3722d2feb24c8; 6'd61: bits = 64'h3ff436e4418e69c0;
         6'd62: bits = 64'h3ff51f4bd13f8591; 6'd63: bits = 64'h3ff64cf55148366f;
         default: bits = 64'h0;
      endcase
      e = bits[62:52];
      m = {1'b1, bits[51:0]};
      sh = 1075 - int'(e) - 32;
      if (bits[62:0] == 63'd0 || sh <= 0 || sh >= 64) r = 64'd0;
      else r = ({11'd0, m} + (64'd1 << (sh - 1))) >> sh;
      return r[33:0];
   endfunction

   // cos(asin(k/64)) = floor(sqrt(2^64 - (k<<26)^2)) in Q.32
   function automatic logic [32:0] cos_rom(input logic [5:0] k);
      logic [127:0] v, t2;
      logic [63:0] r, t;
      logic [63:0] s;
      s = {26'd0, k, 32'd0} >> 6;
      v = (128'd1 << 64) - {64'd0, s} * {64'd0, s};
      r = 64'd0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (64'd1 << b);
         t2 = {64'd0, t} * {64'd0, t};
         if (t2 <= v) r = t;
      end
      return r[32:0];
   endfunction

   // fold both ROMs into constant tables at elaboration
   function automatic asin_table_type asin_table_build();
      asin_table_type tbl;
      for (int k = 0; k < 64; k++) tbl[k] = asin_rom(6'(k));
      return tbl;
   endfunction

   function automatic cos_table_type cos_table_build();
      cos_table_type tbl;
      for (int k = 0; k < 64; k++) tbl[k] = cos_rom(6'(k));
      return tbl;
   endfunction

   localparam asin_table_type ASIN_TABLE = asin_table_build();
   localparam cos_table_type  COS_TABLE  = cos_table_build();

   localparam logic [31:0] C_1_6   = 32'h2AAAAAAB;
   localparam logic [31:0] C_3_40  = 32'h13333333;
   localparam logic [31:0] C_5_112 = 32'h0B6DB6DB;

   typedef struct packed {
      logic [31:0] x;
      logic [5:0]  k;
   } arg_type;

endpackage

// ===== rtl/ats_sqrt_pipe.sv =====
// Pipelined bit-serial square root of 2^64 - x^2, one root bit per stage.
// Depends on ats_pkg.
module ats_sqrt_pipe
   import ats_pkg::*;
(
   input  logic        clock,
   input  logic        advance,
   input  logic [31:0] x_value,
   input  arg_type     arg_in,
   output logic [32:0] root,
   output arg_type     arg_out
);
   localparam int N = 33;
   logic [64:0] rem_ff [N+1];
   logic [32:0] rt_ff  [N+1];
   arg_type     a_ff   [N+1];
   logic [64:0] rem_in [N+1];
   logic [32:0] rt_in  [N+1];

   // radicand 2^64 - x^2 fits in 65 bits
   always_comb begin
      rem_in[0] = 65'h1_0000_0000_0000_0000 - {1'b0, {32'd0, x_value} * {32'd0, x_value}};
      rt_in[0]  = 33'd0;
      for (int i = 1; i <= N; i++) begin
         rem_in[i] = rem_ff[i-1];
         rt_in[i]  = rt_ff[i-1];
      end
   end

   // one restoring step per stage (carry compare on squares, narrow form)
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= rem_in[0];
         rt_ff[0]  <= rt_in[0];
         a_ff[0]   <= arg_in;
         for (int i = 1; i <= N; i++) begin
            logic [32:0] t;
            logic [65:0] sq;
            t  = rt_in[i] | (33'd1 << (N - i));
            sq = {33'd0, t} * {33'd0, t};
            rem_ff[i] <= rem_in[i];
            rt_ff[i]  <= (sq <= {1'b0, rem_in[i]}) ? t : rt_in[i];
            a_ff[i]   <= a_ff[i-1];
         end
      end
   end

   assign root    = rt_ff[N];
   assign arg_out = a_ff[N];
endmodule

// ===== rtl/arcsine_table_taylor_unit.sv =====
// Arcsine unit top level: square root pipe, delta, series and rounding stages.
// Depends on ats_pkg and ats_sqrt_pipe.
// Throughput one request per cycle while the response is not stalled; a response stall holds the whole pipe.
// The sqrt pipe (34 stages) and the multiplier stages set the depth.
// Synchronous active-high reset clears all valid bits; payload is not reset.
module arcsine_table_taylor_unit
   import ats_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_x_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_angle
);
   localparam int SQ = 34;
   localparam int TL = 9;
   localparam int D  = SQ + TL;

   logic advance;
   logic [D-1:0] vld_ff;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[D-1];

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= {vld_ff[D-2:0], req_valid};
   end

   arg_type a0, a1;
   logic [32:0] r;
   assign a0.x = req_x_value;
   assign a0.k = req_x_value[31:26];

   ats_sqrt_pipe u_sqrt (.clock(clock), .advance(advance), .x_value(req_x_value),
      .arg_in(a0), .root(r), .arg_out(a1));

   // tail: products, delta, series, sum
   logic [65:0] p1_ff, p2_ff;
   logic [5:0]  k1_ff, k2_ff, k3_ff, k4_ff, k5_ff, k6_ff, k7_ff;
   logic        n2_ff, n3_ff, n4_ff, n5_ff, n6_ff, n7_ff;
   logic [31:0] d2_ff, d3_ff, d4_ff, d5_ff, d6_ff, d7_ff;
   logic [31:0] q3_ff, q4_ff, q5_ff, t4_ff, t6_ff, u7_ff;
   logic [31:0] dd4_ff, dd5_ff, dd6_ff;
   logic [34:0] s8_ff;
   logic [31:0] o_ff;
   logic [65:0] df_in;
   logic [34:0] sum_in;
   logic [33:0] base;

   assign df_in = (p2_ff > p1_ff) ? p2_ff - p1_ff : p1_ff - p2_ff;
   assign base = ASIN_TABLE[k7_ff];

   always_comb begin
      logic [34:0] ser;
      ser = {3'd0, d7_ff} + {3'd0, u7_ff};
      if (n7_ff) sum_in = ({1'b0, base} < ser) ? 35'd0 : {1'b0, base} - ser;
      else sum_in = {1'b0, base} + ser;
   end

   function automatic logic [31:0] mf(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = {32'd0, a} * {32'd0, b};
      return p[63:32];
   endfunction

   always_ff @(posedge clock) begin
      if (advance) begin
         // x*c and s*r
         p1_ff <= {34'd0, a1.x} * {33'd0, COS_TABLE[a1.k]};
         p2_ff <= {34'd0, a1.k, 26'd0} * {33'd0, r};
         k1_ff <= a1.k;
         // delta magnitude and sign
         d2_ff <= df_in[63:32];
         n2_ff <= p2_ff > p1_ff;
         k2_ff <= k1_ff;
         // d2 = d*d
         q3_ff <= mf(d2_ff, d2_ff); d3_ff <= d2_ff; n3_ff <= n2_ff; k3_ff <= k2_ff;
         // t = 3/40 + d2*5/112 ; dd = d*d2
         t4_ff <= C_3_40 + mf(q3_ff, C_5_112);
         dd4_ff <= mf(d3_ff, q3_ff);
         q4_ff <= q3_ff; d4_ff <= d3_ff; n4_ff <= n3_ff; k4_ff <= k3_ff;
         // d2*t
         q5_ff <= mf(q4_ff, t4_ff); dd5_ff <= dd4_ff;
         d5_ff <= d4_ff; n5_ff <= n4_ff; k5_ff <= k4_ff;
         // t = 1/6 + d2*t
         t6_ff <= C_1_6 + q5_ff; dd6_ff <= dd5_ff;
         d6_ff <= d5_ff; n6_ff <= n5_ff; k6_ff <= k5_ff;
         // dd*t
         u7_ff <= mf(dd6_ff, t6_ff); d7_ff <= d6_ff; n7_ff <= n6_ff; k7_ff <= k6_ff;
         // add base
         s8_ff <= sum_in;
         // round to Q1.31, saturate
         o_ff <= (s8_ff + 35'd1 >= 35'h2_0000_0000) ? 32'hFFFFFFFF
                 : 32'((s8_ff + 35'd1) >> 1);
      end
   end

   assign rsp_angle = o_ff;

   logic unused;
   assign unused = ^{df_in[65:64], df_in[31:0]};
endmodule

// ===== verif/arcsine_table_taylor_unit_test.sv =====
// Self-checking testbench for arcsine_table_taylor_unit: directed table, then random x values.
// Depends on the unit RTL; expected angles come from a bit-exact local predictor.
`timescale 1ns / 1ps

module arcsine_table_taylor_unit_test;

   localparam int HOLD_OFF    = 60;
   localparam int STALL_LIMIT = 5000;
   localparam int RANDOM_ITEMS = 1200;

   typedef struct {
      logic [31:0] x;
      bit          known;
      logic [31:0] angle;
   } stim_row_type;

   // asin(k/64) as binary64 bit patterns, k = 0..63
   localparam logic [63:0] ASIN_BITS [64] = '{
      64'h0000000000000000, 64'h3f90002aabdde94c, 64'h3fa000aabde0b9c8, 64'h3fa8024091fdb0a9,
      64'h3fb002abde953619, 64'h3fb405390240e6fd, 64'h3fb809092913e52e, 64'h3fbc0e5e80f7172d,
      64'h3fc00abe0c129e1e, 64'h3fc20f530308cc20, 64'h3fc41510cb011423, 64'h3fc61c1ab9d55d30,
      64'h3fc82494ed0e78fc, 64'h3fca2ea462b4998e, 64'h3fcc3a6f13aae84b, 64'h3fce481c0fce7134,
      64'h3fd02be9ce0b87cd, 64'h3fd134dfa9805147, 64'h3fd23f0523c5dc2b, 64'h3fd34a709597aab1,
      64'h3fd457393b90e2aa, 64'h3fd565774cb66f02, 64'h3fd675441329986e, 64'h3fd786ba074fef93,
      64'h3fd899f4edc962d3, 64'h3fd9af11f89ba61c, 64'h3fdac62fec0b2a92, 64'h3fdbdf6f47ae6904,
      64'h3fdcfaf27460fe9f, 64'h3fde18ddf7da106b, 64'h3fdf3958aecddef4, 64'h3fe02e46075785a1,
      64'h3fe0c152382d7366, 64'h3fe155e8b2a00052, 64'h3fe1ec230c714a96, 64'h3fe2841ce0862975,
      64'h3fe31df40fbd31cd, 64'h3fe3b9c90c43296d, 64'h3fe457bf318fe517, 64'h3fe4f7fd2bc2fb34,
      64'h3fe59aad71ced00f, 64'h3fe63ffed6d198f6, 64'h3fe6e825383cc40b, 64'h3fe7935a501afa78,
      64'h3fe841deb5114bb4, 64'h3fe8f3fb14e496b4, 64'h3fe9aa01babef75e, 64'h3fea645078c6a78c,
      64'h3feb235315c680dc, 64'h3febe7866d3b6481, 64'h3fecb17c849c7288, 64'h3fed81e1f875ea8d,
      64'h3fee5985567b665d, 64'h3fef39614cbef7d4, 64'h3ff0115591d29d12, 64'h3ff08b73f9af1058,
      64'h3ff10c066d3e6932, 64'h3ff194590de7e7f6, 64'h3ff2263461820ad8, 64'h3ff2c42a3a3c7a87,
      64'h3ff3722d2feb24c8, 64'h3ff436e4418e69c0, 64'h3ff51f4bd13f8591, 64'h3ff64cf55148366f
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_x_value = 32'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_angle;

   logic [31:0] angle_queue [$];
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          mismatches = 0;
   int          quiet_cycles = 0;

   arcsine_table_taylor_unit dut (.*);

   always #1 clock = ~clock;

   // floor square root of a radicand below 2^66
   function automatic logic [63:0] floor_root(input logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  t;
      r = 64'd0;
      for (int b = 33; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if ({64'd0, t} * {64'd0, t} <= v) r = t;
      end
      return r;
   endfunction

   // Q.32 product, truncated
   function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[95:32];
   endfunction

   // binary64 pattern to Q.32, rounded to nearest
   function automatic logic [63:0] decode_q32(input logic [63:0] bits);
      int          sh;
      logic [63:0] m;
      if (bits[62:0] == 63'd0) return 64'd0;
      m = {11'd0, 1'b1, bits[51:0]};
      sh = 1075 - int'(bits[62:52]) - 32;
      if (sh <= 0) return (sh > -11) ? (m << (-sh)) : 64'd0;
      if (sh >= 64) return 64'd0;
      return (m + (64'd1 << (sh - 1))) >> sh;
   endfunction

   function automatic logic [63:0] recip_q32(input logic [63:0] num, input logic [63:0] den);
      return ((num << 32) + den / 2) / den;
   endfunction

   // predicted asin(x) in Q1.31
   function automatic logic [31:0] predict_angle(input logic [31:0] xv);
      logic [5:0]   k;
      logic [63:0]  x, s, c, r, d, d2, t, series, base, angle;
      logic [127:0] p1, p2;
      bit           neg;
      k = xv[31:26];
      x = {32'd0, xv};
      s = {32'd0, k, 26'd0};
      c = floor_root((128'd1 << 64) - {64'd0, s} * {64'd0, s});
      r = floor_root((128'd1 << 64) - {64'd0, x} * {64'd0, x});
      p1 = {64'd0, x} * {64'd0, c};
      p2 = {64'd0, s} * {64'd0, r};
      neg = p2 > p1;
      d = neg ? 64'((p2 - p1) >> 32) : 64'((p1 - p2) >> 32);
      d2 = mul_q32(d, d);
      t = recip_q32(64'd3, 64'd40) + mul_q32(d2, recip_q32(64'd5, 64'd112));
      t = recip_q32(64'd1, 64'd6) + mul_q32(d2, t);
      series = d + mul_q32(mul_q32(d, d2), t);
      base = decode_q32(ASIN_BITS[k]);
      if (neg) angle = (series > base) ? 64'd0 : base - series;
      else angle = base + series;
      angle = (angle + 64'd1) >> 1;
      if (angle > 64'hFFFF_FFFF) angle = 64'hFFFF_FFFF;
      return angle[31:0];
   endfunction

   // Offer one transaction, hold until accepted, then maybe idle
   task automatic send_x(input logic [31:0] xv, input bit known, input logic [31:0] angle);
      req_valid   <= 1'b1;
      req_x_value <= xv;
      do @(posedge clock); while (req_stall);
      angle_queue.push_back(known ? angle : predict_angle(xv));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Random argument: full range, near breakpoints, tiny, or near one
   function automatic logic [31:0] pick_x();
      logic [31:0] base;
      unique case ($urandom_range(3))
         0: return $urandom;
         1: begin
            base = {6'($urandom_range(63)), 26'd0};
            return base + $urandom_range(15) - 32'd8;
         end
         2: return $urandom_range(32'h0000_FFFF);
         default: return 32'hFFFF_FFFF - $urandom_range(32'h000F_FFFF);
      endcase
   endfunction

   // Receive side: check each transaction, draw the next stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (angle_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected angle %h", rsp_angle);
            end else if (angle_queue[0] !== rsp_angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("angle mismatch: expected %h actual %h", angle_queue[0], rsp_angle);
               void'(angle_queue.pop_front());
            end else begin
               void'(angle_queue.pop_front());
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Watchdog: drop the run after too long without a transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      stim_row_type rows [20];
      rows = '{
         '{32'h0000_0000, 1'b1, 32'h0000_0000},
         '{32'h0000_0001, 1'b0, 32'h0}, '{32'hFFFF_FFFF, 1'b0, 32'h0},
         '{32'h8000_0000, 1'b0, 32'h0}, '{32'h7FFF_FFFF, 1'b0, 32'h0},
         '{32'h0400_0000, 1'b0, 32'h0}, '{32'h03FF_FFFF, 1'b0, 32'h0},
         '{32'h0400_0001, 1'b0, 32'h0}, '{32'hFC00_0000, 1'b0, 32'h0},
         '{32'hFBFF_FFFF, 1'b0, 32'h0}, '{32'hFC00_0001, 1'b0, 32'h0},
         '{32'hFFFF_FFFE, 1'b0, 32'h0}, '{32'h5555_5555, 1'b0, 32'h0},
         '{32'hAAAA_AAAA, 1'b0, 32'h0}, '{32'h0000_FFFF, 1'b0, 32'h0},
         '{32'hFFFF_0000, 1'b0, 32'h0}, '{32'h6ED9_EBA1, 1'b0, 32'h0},
         '{32'hDDB3_D742, 1'b0, 32'h0}, '{32'h03FF_FFF0, 1'b0, 32'h0},
         '{32'hB504_F334, 1'b0, 32'h0}
      };

      // Hold reset, then walk the directed table
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send_x(rows[i].x, rows[i].known, rows[i].angle);

      // Pause until the pipe drains
      req_valid <= 1'b0;
      while (angle_queue.size() != 0) @(posedge clock);
      @(posedge clock);

      // Three phases of random arguments; the last one has no idling and no stalls
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 27 : (phase == 1) ? 59 : 0;
         recv_stall_pct = (phase == 0) ? 59 : (phase == 1) ? 27 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) send_x(pick_x(), 1'b0, 32'h0);
      end
      req_valid <= 1'b0;

      // Drain and let the pipe settle
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
      if (mismatches == 0 && angle_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
